[design/sida_pkg.sv]
`timescale 1ns / 1ps

package sida_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int INPUT_WIDTH = 32;
    localparam int MAG_WIDTH   = VALUE_WIDTH;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIGIT_W     = 4;

    // Decimal digits in the largest magnitude, 2^(VALUE_WIDTH-1).
    function automatic int digit_count();
        longint unsigned p;
        longint unsigned top;
        int n;
        p   = 1;
        top = 64'd1 << (VALUE_WIDTH - 1);
        n   = 1;
        for (int i = 0; i < 20; i++) begin
            if (p * 10 <= top) begin
                p = p * 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int MAX_DIGITS = digit_count();
    localparam int DCOUNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W     = $clog2(MAX_DIGITS);

    // floor(x / 10) = (x * RECIP) >> RECIP_SHIFT for every x below 2^32.
    localparam int                  RECIP_W     = 32;
    localparam logic [RECIP_W-1:0]  RECIP       = 32'hCCCC_CCCD;
    localparam int                  RECIP_SHIFT = 35;

    localparam logic [DIGIT_W-1:0]    DIGIT_BASE = 4'd10;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic                 neg;
        logic [MAG_WIDTH-1:0] mag;
    } job_t;

endpackage

[design/sida_value_if.sv]
`timescale 1ns / 1ps

interface sida_value_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sida_pkg::INPUT_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[design/sida_char_if.sv]
`timescale 1ns / 1ps

interface sida_char_if;
    logic                            valid;
    logic                            ready;
    logic [sida_pkg::CHAR_WIDTH-1:0] character;
    logic                            last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

[design/signed_int_to_decimal_ascii_top.sv]
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// Channel num takes one two's complement value per request (valid/ready).
// Channel text returns its decimal text one character per request: '-' for a
// negative value, then the digits most significant first with no leading
// zeros; last_char marks the final character. The most negative value is
// converted exactly.
// A front stage forms sign and magnitude and writes them into a two-entry
// queue, so further values are taken while one is being converted.
// The back unit peels one digit per cycle with a multiply-by-reciprocal
// divide by ten, then sends one character per cycle from its output register
// while text is ready: S_IDLE takes a job, S_DIV peels its digits and S_EMIT
// sends '-' for a negative value, then the digits.
// Reset clears the queue, the sequencer and the output valid.
// When text stalls, the character in the output register holds; the
// conversion pauses and the queue fills, after which num.ready drops.

module signed_int_to_decimal_ascii_top (
    input  logic         clk,
    input  logic         rst_n,
    sida_value_if.sink   num,
    sida_char_if.source  text
);

    logic           push_valid, push_ready;
    sida_pkg::job_t push_job;
    logic           job_valid, job_ready;
    sida_pkg::job_t job;

    sida_front u_front (
        .num        (num),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sida_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (job_valid),
        .out_ready (job_ready),
        .out_job   (job)
    );

    sida_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .text      (text)
    );

    // A negative job never carries a zero magnitude.
    a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready && job.neg) |-> (job.mag != '0))
        else $error("negative job with zero magnitude");

    // The minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.character == sida_pkg::CHAR_MINUS) |-> !text.last_char)
        else $error("minus sign flagged last");

    // Only '-' or a decimal digit leaves the block.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid |-> (text.character == sida_pkg::CHAR_MINUS ||
                        (text.character >= sida_pkg::CHAR_ZERO &&
                         text.character <= sida_pkg::CHAR_ZERO + 8'd9)))
        else $error("illegal output character");

endmodule

[design/sida_front.sv]
`timescale 1ns / 1ps

module sida_front (
    sida_value_if.sink            num,
    output logic                  push_valid,
    input  logic                  push_ready,
    output sida_pkg::job_t        push_job
);

    logic [sida_pkg::VALUE_WIDTH-1:0] raw;

    // Only the low VALUE_WIDTH bits count; the most negative value negates to itself,
    // which read unsigned is its true magnitude.
    assign raw          = num.value[sida_pkg::VALUE_WIDTH-1:0];
    assign push_job.neg = raw[sida_pkg::VALUE_WIDTH-1];
    assign push_job.mag = raw[sida_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign push_valid   = num.valid;
    assign num.ready    = push_ready;

endmodule

[design/sida_queue.sv]
`timescale 1ns / 1ps

module sida_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sida_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output sida_pkg::job_t out_job
);

    sida_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

[design/sida_back.sv]
`timescale 1ns / 1ps

module sida_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  sida_pkg::job_t job,
    sida_char_if.source    text
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic                              neg_reg, neg_next;
    logic                              sign_reg, sign_next;
    logic [sida_pkg::DCOUNT_W-1:0]     cnt_reg, cnt_next;
    logic [sida_pkg::DIDX_W-1:0]       idx_reg, idx_next;
    logic                              ovalid_reg, ovalid_next;
    logic [sida_pkg::CHAR_WIDTH-1:0]   char_reg, char_next;
    logic                              last_reg, last_next;
    logic [sida_pkg::MAG_WIDTH-1:0]    x_reg, x_next;
    logic [sida_pkg::DIGIT_W-1:0]      digits [sida_pkg::MAX_DIGITS];

    logic [2*sida_pkg::RECIP_W-1:0]    prod;
    logic [sida_pkg::MAG_WIDTH-1:0]    quot;
    logic [sida_pkg::DIGIT_W-1:0]      rem;
    logic                              digit_we;

    // Divide by ten through the reciprocal; the remainder is below ten, so four
    // low bits of x - 10q are enough.
    assign prod = sida_pkg::RECIP_W'(x_reg) * sida_pkg::RECIP;
    assign quot = sida_pkg::MAG_WIDTH'(prod >> sida_pkg::RECIP_SHIFT);
    assign rem  = x_reg[sida_pkg::DIGIT_W-1:0]
                - sida_pkg::DIGIT_W'(quot[sida_pkg::DIGIT_W-1:0] * sida_pkg::DIGIT_BASE);

    assign text.valid     = ovalid_reg;
    assign text.character = char_reg;
    assign text.last_char = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        x_next      = x_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        job_ready   = 1'b0;
        digit_we    = 1'b0;

        // Drop the held character once taken; a new one may replace it below.
        if (ovalid_reg && text.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    x_next     = job.mag;
                    neg_next   = job.neg;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                digit_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                x_next   = quot;
                if (quot == '0)
                begin
                    idx_next   = cnt_reg[sida_pkg::DIDX_W-1:0];
                    sign_next  = neg_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || text.ready)
                begin
                    ovalid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = sida_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = sida_pkg::CHAR_ZERO
                                  + {{(sida_pkg::CHAR_WIDTH-sida_pkg::DIGIT_W){1'b0}},
                                     digits[idx_reg]};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            neg_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            neg_reg    <= neg_next;
            sign_reg   <= sign_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (digit_we)
        begin
            digits[cnt_reg[sida_pkg::DIDX_W-1:0]] <= rem;
        end
    end

endmodule

[bench/signed_int_to_decimal_ascii_top_tb.sv]
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int CALM_ITEMS  = 20;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 30;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [sida_pkg::CHAR_WIDTH-1:0]  character;
        logic                             last_char;
        logic [sida_pkg::INPUT_WIDTH-1:0] source;
    } text_char_t;

    logic clk;
    logic rst_n;

    sida_value_if num_if ();
    sida_char_if  text_if ();

    signed_int_to_decimal_ascii_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if.sink),
        .text  (text_if.source)
    );

    logic [sida_pkg::INPUT_WIDTH-1:0] values_pending[$];
    text_char_t                       text_expected[$];

    int  values_taken = 0;
    int  error_count = 0;
    int  send_gap;
    int  recv_gap;
    int  idle_cycles = 0;
    bit  text_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what,
                                   input logic [sida_pkg::INPUT_WIDTH-1:0] src,
                                   input int got, input int want);
        $display("ERROR %0t: %s for value %0d: got %0d, want %0d",
                 $realtime, what, $signed(src), got, want);
        error_count++;
    endtask

    // Decimal text of one value: optional '-' then digits, most significant first.
    task automatic predict_text(input logic [sida_pkg::INPUT_WIDTH-1:0] v);
        longint unsigned raw;
        longint unsigned mag;
        logic            neg;
        int              digits[20];
        int              nd;
        text_char_t      c;
        raw = 0;
        raw[sida_pkg::VALUE_WIDTH-1:0] = v[sida_pkg::VALUE_WIDTH-1:0];
        neg = raw[sida_pkg::VALUE_WIDTH-1];
        mag = neg ? ((64'd1 << sida_pkg::VALUE_WIDTH) - raw) : raw;
        nd  = 0;
        do
        begin
            digits[nd] = int'(mag % 10);
            nd++;
            mag = mag / 10;
        end
        while (mag != 0);
        c.source = v;
        if (neg)
        begin
            c.character = sida_pkg::CHAR_MINUS;
            c.last_char = 1'b0;
            text_expected.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.character = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_WIDTH'(digits[k]);
            c.last_char = (k == 0);
            text_expected.push_back(c);
        end
    endtask

    // Driver: offer pending values, hold a request until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_if.valid <= 1'b0;
            num_if.value <= '0;
            send_gap = 0;
        end
        else
        begin
            if (num_if.valid && num_if.ready)
            begin
                predict_text(num_if.value);
                values_taken++;
            end
            if (!(num_if.valid && !num_if.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    num_if.valid <= 1'b0;
                end
                else if (values_pending.size() >= CALM_ITEMS && $urandom_range(0, 6) == 0)
                begin
                    send_gap = $urandom_range(1, 12) - 1;
                    num_if.valid <= 1'b0;
                end
                else if (values_pending.size() > 0)
                begin
                    num_if.valid <= 1'b1;
                    num_if.value <= values_pending.pop_front();
                end
                else
                begin
                    num_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each character against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            text_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                if (text_expected.size() == 0)
                begin
                    report_mismatch("unexpected character", '0,
                                    int'(text_if.character), -1);
                end
                else
                begin
                    want = text_expected.pop_front();
                    if (text_if.character !== want.character)
                        report_mismatch("character", want.source,
                                        int'(text_if.character), int'(want.character));
                    if (text_if.last_char !== want.last_char)
                        report_mismatch("last_char", want.source,
                                        int'(text_if.last_char), int'(want.last_char));
                end
            end
            if (text_hold)
            begin
                text_if.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                text_if.ready <= 1'b0;
            end
            else if (values_pending.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(1, 12) - 1;
                text_if.ready <= 1'b0;
            end
            else
            begin
                text_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((num_if.valid && num_if.ready) || (text_if.valid && text_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("signed_int_to_decimal_ascii_top: mismatch");
                $finish;
            end
        end
    end

    // Long receiver stall so the front queue fills and input backs up.
    initial
    begin
        text_hold = 1'b0;
        do
            @(negedge clk);
        while (values_taken < HOLD_AFTER);
        text_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        text_hold = 1'b0;
    end

    initial
    begin
        longint                           p10;
        longint                           m;
        int                               k;
        logic [sida_pkg::INPUT_WIDTH-1:0] v;

        rst_n = 1'b0;

        // Directed: zero, single digits, digit-count boundaries, both extremes.
        values_pending.push_back(32'd0);
        values_pending.push_back(32'd1);
        values_pending.push_back(-32'sd1);
        values_pending.push_back(32'd9);
        values_pending.push_back(32'd10);
        values_pending.push_back(-32'sd9);
        values_pending.push_back(-32'sd10);
        values_pending.push_back(32'd99);
        values_pending.push_back(32'd100);
        values_pending.push_back(32'd999999999);
        values_pending.push_back(32'd1000000000);
        values_pending.push_back(-32'sd1000000000);
        values_pending.push_back(32'h7FFF_FFFF);
        values_pending.push_back(32'h8000_0000);
        values_pending.push_back(32'h8000_0001);
        values_pending.push_back(32'h5555_5555);
        values_pending.push_back(32'hAAAA_AAAA);
        values_pending.push_back(32'd1000);
        values_pending.push_back(32'd100000);
        values_pending.push_back(-32'sd12345);

        for (int i = 0; i < 110; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1:
                begin
                    m = $urandom_range(0, 999);
                    v = ($urandom_range(0, 1) != 0) ? sida_pkg::INPUT_WIDTH'(-m)
                                                    : sida_pkg::INPUT_WIDTH'(m);
                end
                2:
                begin
                    k   = $urandom_range(1, 10);
                    p10 = 1;
                    repeat (k) p10 = p10 * 10;
                    m = longint'($urandom) % p10;
                    v = ($urandom_range(0, 1) != 0) ? sida_pkg::INPUT_WIDTH'(-m)
                                                    : sida_pkg::INPUT_WIDTH'(m);
                end
                default:
                begin
                    m = $urandom_range(0, 15);
                    v = ($urandom_range(0, 1) != 0)
                      ? (32'h8000_0000 + sida_pkg::INPUT_WIDTH'(m))
                      : (32'h7FFF_FFFF - sida_pkg::INPUT_WIDTH'(m));
                end
            endcase
            values_pending.push_back(v);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (values_pending.size() != 0 || num_if.valid || text_expected.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (error_count == 0 && text_expected.size() == 0)
            $display("signed_int_to_decimal_ascii_top: match");
        else
            $display("signed_int_to_decimal_ascii_top: mismatch");
        $finish;
    end

endmodule
